[design/yrab_pkg.sv]
// shared types and constants for the register, alu and branch unit
package yrab_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int REG_COUNT = 8;
    localparam int FUNC_W    = 4;
    localparam int IN_W      = 80;
    localparam int OUT_W     = 72;

    typedef enum logic [1:0] {
        ACT_MOVE = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_ALU  = 2'd2,
        ACT_JUMP = 2'd3
    } action_t;

    typedef enum logic [FUNC_W-1:0] {
        ALU_ADD = 4'd0,
        ALU_SUB = 4'd1,
        ALU_AND = 4'd2,
        ALU_XOR = 4'd3,
        ALU_MUL = 4'd4,
        ALU_CMP = 4'd5
    } alu_func_t;

    typedef enum logic [FUNC_W-1:0] {
        JMP_ALWAYS = 4'd0,
        JMP_LE     = 4'd1,
        JMP_LT     = 4'd2,
        JMP_EQ     = 4'd3,
        JMP_NE     = 4'd4,
        JMP_GE     = 4'd5,
        JMP_GT     = 4'd6
    } jump_func_t;

    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } flags_t;

    typedef struct packed {
        logic [WORD_W-1:0] written;
        logic [WORD_W-1:0] npc;
        logic              taken;
        flags_t            flags;
        logic              bad;
        logic              reg_we;
    } exec_res_t;

endpackage

[design/yrab_ram.sv]
// generic single write port, single read port ram with registered read
module yrab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/yrab_exec.sv]
// execute logic: alu, flag update, jump condition and status
module yrab_exec
    import yrab_pkg::*;
(
    input  action_t           action,
    input  logic [FUNC_W-1:0] func,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  logic [WORD_W-1:0] immediate,
    input  logic [WORD_W-1:0] fall_through_pc,
    input  flags_t            flags_in,
    output exec_res_t         res
);

    logic signed [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]          r;
    logic                       of_new;
    logic                       alu_bad;
    logic                       take;

    always_comb
    begin
        prod    = $signed(a) * $signed(b);
        r       = '0;
        of_new  = 1'b0;
        alu_bad = 1'b0;
        unique case (func)
            ALU_ADD:
            begin
                r      = b + a;
                of_new = ~(a[WORD_W-1] ^ b[WORD_W-1]) & (r[WORD_W-1] ^ b[WORD_W-1]);
            end
            ALU_SUB, ALU_CMP:
            begin
                r      = b - a;
                of_new = (a[WORD_W-1] ^ b[WORD_W-1]) & (r[WORD_W-1] ^ b[WORD_W-1]);
            end
            ALU_AND: r = b & a;
            ALU_XOR: r = b ^ a;
            ALU_MUL:
            begin
                r      = prod[WORD_W-1:0];
                of_new = ~((&prod[2*WORD_W-1:WORD_W-1]) | ~(|prod[2*WORD_W-1:WORD_W-1]));
            end
            default: alu_bad = 1'b1;
        endcase
    end

    always_comb
    begin
        take = 1'b0;
        unique case (func)
            JMP_ALWAYS: take = 1'b1;
            JMP_LE:     take = (flags_in.sf ^ flags_in.of) | flags_in.zf;
            JMP_LT:     take = flags_in.sf ^ flags_in.of;
            JMP_EQ:     take = flags_in.zf;
            JMP_NE:     take = ~flags_in.zf;
            JMP_GE:     take = ~(flags_in.sf ^ flags_in.of);
            JMP_GT:     take = ~(flags_in.sf ^ flags_in.of) & ~flags_in.zf;
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        res.written = '0;
        res.npc     = fall_through_pc;
        res.taken   = 1'b0;
        res.flags   = flags_in;
        res.bad     = 1'b0;
        res.reg_we  = 1'b0;
        unique case (action)
            ACT_MOVE:
            begin
                res.written = a;
                res.reg_we  = 1'b1;
            end
            ACT_LOAD:
            begin
                res.written = immediate;
                res.reg_we  = 1'b1;
            end
            ACT_ALU:
            begin
                res.bad = alu_bad;
                if (!alu_bad)
                begin
                    res.written  = r;
                    res.flags.zf = (r == '0);
                    res.flags.sf = r[WORD_W-1];
                    res.flags.of = of_new;
                    res.reg_we   = (func != ALU_CMP);
                end
            end
            ACT_JUMP:
            begin
                res.bad   = (func > JMP_GT);
                res.taken = take;
                if (take)
                begin
                    res.npc = immediate;
                end
            end
            default: res.bad = 1'b0;
        endcase
    end

endmodule

[design/y86_register_alu_branch_unit.sv]
// top level: register file rams, forwarding, execute stage and output register
//
// channel  dir  fields (lowest bit first)
// s_*      in   action, func, reg_a, reg_b, immediate, fall_through_pc
// m_*      out  written_value, next_pc, jump_taken, zero_flag, sign_flag,
//               overflow_flag, status_code
//
// one word per cycle if unstalled; execute regs then the output register hold the result
// stage 0 issues both register reads into the rams, stage 1 executes and writes back
// a write is forwarded to the word read in the same cycle; flags live in flops
// reset clears the valid bits so unwritten registers read as zero
// a stalled output holds the execute stage and the input
module y86_register_alu_branch_unit
    import yrab_pkg::*;
#(
    parameter int NUM_REGISTERS = REG_COUNT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // action, func, reg_a, reg_b, immediate, fall_through_pc, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // written_value, next_pc, jump_taken, zero_flag, sign_flag, overflow_flag,
    // status_code, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(NUM_REGISTERS);

    logic                 s_fire;
    logic                 x_fire;
    logic                 x_valid_reg;
    action_t              x_action_reg;
    logic [FUNC_W-1:0]    x_func_reg;
    logic [AW-1:0]        x_ra_reg;
    logic [AW-1:0]        x_rb_reg;
    logic [WORD_W-1:0]    x_imm_reg;
    logic [WORD_W-1:0]    x_fall_reg;

    logic [AW-1:0]        in_ra;
    logic [AW-1:0]        in_rb;
    logic [WORD_W-1:0]    ram_a;
    logic [WORD_W-1:0]    ram_b;
    logic [WORD_W-1:0]    op_a;
    logic [WORD_W-1:0]    op_b;

    logic [NUM_REGISTERS-1:0] vld_reg;
    logic                 fwd_valid_reg;
    logic [AW-1:0]        fwd_addr_reg;
    logic [WORD_W-1:0]    fwd_data_reg;
    flags_t               flags_reg;

    exec_res_t            res;
    logic                 wr_en;

    logic                 out_valid_reg;
    exec_res_t            out_reg;

    assign in_ra = s_tdata[6+AW-1:6];
    assign in_rb = s_tdata[9+AW-1:9];

    assign x_fire   = x_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !x_valid_reg || x_fire;
    assign s_fire   = s_tvalid && s_tready;
    assign wr_en    = x_fire && res.reg_we;

    yrab_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGISTERS)) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (x_rb_reg),
        .wdata (res.written),
        .re    (s_fire),
        .raddr (in_ra),
        .rdata (ram_a)
    );

    yrab_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGISTERS)) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (x_rb_reg),
        .wdata (res.written),
        .re    (s_fire),
        .raddr (in_rb),
        .rdata (ram_b)
    );

    // operand select: forwarded write, then ram, then reset value
    always_comb
    begin
        priority if (fwd_valid_reg && fwd_addr_reg == x_ra_reg)
            op_a = fwd_data_reg;
        else if (vld_reg[x_ra_reg])
            op_a = ram_a;
        else
            op_a = '0;
        priority if (fwd_valid_reg && fwd_addr_reg == x_rb_reg)
            op_b = fwd_data_reg;
        else if (vld_reg[x_rb_reg])
            op_b = ram_b;
        else
            op_b = '0;
    end

    yrab_exec u_exec (
        .action          (x_action_reg),
        .func            (x_func_reg),
        .a               (op_a),
        .b               (op_b),
        .immediate       (x_imm_reg),
        .fall_through_pc (x_fall_reg),
        .flags_in        (flags_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                x_valid_reg <= s_tvalid;
            end
            if (x_fire)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= res.flags;
                fwd_valid_reg <= res.reg_we;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                vld_reg[x_rb_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            x_action_reg <= action_t'(s_tdata[1:0]);
            x_func_reg   <= s_tdata[5:2];
            x_ra_reg     <= in_ra;
            x_rb_reg     <= in_rb;
            x_imm_reg    <= s_tdata[43:12];
            x_fall_reg   <= s_tdata[75:44];
        end
        if (x_fire)
        begin
            out_reg <= res;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= x_rb_reg;
            fwd_data_reg <= res.written;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.bad, out_reg.flags.of, out_reg.flags.sf,
                       out_reg.flags.zf, out_reg.taken, out_reg.npc, out_reg.written};

endmodule
